FILE: rtl/core/sot_pkg.sv
package sot_pkg;

    // Coordinate format: signed 16.16 fixed point.
    localparam int CoordW = 32;
    localparam int FracW  = 16;
    // Integer part of a coordinate difference (33-bit difference, floored).
    localparam int IntW   = CoordW + 1 - FracW;
    localparam int ProdW  = 2 * IntW;
    localparam int CrossW = ProdW + 1;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [IntW-1:0]   ipart_t;
    typedef logic signed [ProdW-1:0]  prod_t;

    // Orientation codes: {negative, nonzero}.
    typedef logic [1:0] orient_t;
    localparam orient_t OrientZero = 2'b00;
    localparam orient_t OrientPos  = 2'b01;
    localparam orient_t OrientNeg  = 2'b11;

    // Decisions that are settled before the cross products are known.
    typedef struct packed {
        logic decided;
        logic early;
        logic coll;
    } flags_t;

    // Floored integer parts of the coordinate differences.
    typedef struct packed {
        ipart_t a_sx;
        ipart_t a_sy;
        ipart_t b1_dx;
        ipart_t b1_dy;
        ipart_t b2_dx;
        ipart_t b2_dy;
        ipart_t b_sx;
        ipart_t b_sy;
        ipart_t a1_dx;
        ipart_t a1_dy;
        ipart_t a2_dx;
        ipart_t a2_dy;
        flags_t flags;
    } front_t;

    // Cross product terms: each orientation is p minus q.
    typedef struct packed {
        prod_t  d1_p;
        prod_t  d1_q;
        prod_t  d2_p;
        prod_t  d2_q;
        prod_t  e1_p;
        prod_t  e1_q;
        prod_t  e2_p;
        prod_t  e2_q;
        flags_t flags;
    } prod_s_t;

    // Floor of (a - b) / 2^16, with the difference kept at full width.
    function automatic ipart_t int_part(input coord_t a, input coord_t b);
        logic signed [CoordW:0] diff;
        diff = {a[CoordW-1], a} - {b[CoordW-1], b};
        return diff[CoordW:FracW];
    endfunction

    // Sign of p - q, computed one bit wider than the products.
    function automatic orient_t orient_code(input prod_t p, input prod_t q);
        logic signed [CrossW-1:0] c;
        orient_t code;
        c = {p[ProdW-1], p} - {q[ProdW-1], q};
        if (c[CrossW-1])
        begin
            code = OrientNeg;
        end
        else if (c != '0)
        begin
            code = OrientPos;
        end
        else
        begin
            code = OrientZero;
        end
        return code;
    endfunction

endpackage

FILE: rtl/core/sot_front.sv
module sot_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sot_pkg::coord_t ax1,
    input  sot_pkg::coord_t ay1,
    input  sot_pkg::coord_t ax2,
    input  sot_pkg::coord_t ay2,
    input  sot_pkg::coord_t bx1,
    input  sot_pkg::coord_t by1,
    input  sot_pkg::coord_t bx2,
    input  sot_pkg::coord_t by2,
    output logic            out_valid,
    input  logic            out_ready,
    output sot_pkg::front_t out_data
);
    import sot_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    front_t data_reg;
    front_t data_next;
    logic   advance;

    logic box_ok;
    logic deg_a;
    logic deg_b;
    logic hit_a;
    logic hit_b;
    logic coll;

    // Endpoint range check along x, or along y when x is constant; a point segment checks px >= sx and py >= sy.
    function automatic logic in_range(input coord_t sx, input coord_t sy,
                                      input coord_t ex, input coord_t ey,
                                      input coord_t px, input coord_t py);
        logic r;
        if (ex > sx)
        begin
            r = (px >= sx) && (px <= ex);
        end
        else if (ex < sx)
        begin
            r = (px >= ex) && (px <= sx);
        end
        else if (ey > sy)
        begin
            r = (py >= sy) && (py <= ey);
        end
        else if (ey < sy)
        begin
            r = (py >= ey) && (py <= sy);
        end
        else
        begin
            r = (px >= sx) && (py >= sy);
        end
        return r;
    endfunction

    // Bounding boxes overlap, edges included.
    always_comb
    begin
        coord_t amin_x;
        coord_t amax_x;
        coord_t amin_y;
        coord_t amax_y;
        coord_t bmin_x;
        coord_t bmax_x;
        coord_t bmin_y;
        coord_t bmax_y;
        amin_x = (ax1 < ax2) ? ax1 : ax2;
        amax_x = (ax1 > ax2) ? ax1 : ax2;
        amin_y = (ay1 < ay2) ? ay1 : ay2;
        amax_y = (ay1 > ay2) ? ay1 : ay2;
        bmin_x = (bx1 < bx2) ? bx1 : bx2;
        bmax_x = (bx1 > bx2) ? bx1 : bx2;
        bmin_y = (by1 < by2) ? by1 : by2;
        bmax_y = (by1 > by2) ? by1 : by2;
        box_ok = (amin_x <= bmax_x) && (amax_x >= bmin_x) &&
                 (amin_y <= bmax_y) && (amax_y >= bmin_y);
    end

    // Degenerate segments match only the other segment's endpoints.
    assign deg_a = (ax1 == ax2) && (ay1 == ay2);
    assign deg_b = (bx1 == bx2) && (by1 == by2);
    assign hit_a = ((ax1 == bx1) && (ay1 == by1)) || ((ax1 == bx2) && (ay1 == by2));
    assign hit_b = ((bx1 == ax1) && (by1 == ay1)) || ((bx1 == ax2) && (by1 == ay2));

    // Collinear fallback: any endpoint within the other segment's range.
    assign coll = in_range(ax1, ay1, ax2, ay2, bx1, by1) ||
                  in_range(ax1, ay1, ax2, ay2, bx2, by2) ||
                  in_range(bx1, by1, bx2, by2, ax1, ay1) ||
                  in_range(bx1, by1, bx2, by2, ax2, ay2);

    // Next stage contents.
    always_comb
    begin
        data_next.a_sx  = int_part(ax2, ax1);
        data_next.a_sy  = int_part(ay2, ay1);
        data_next.b1_dx = int_part(bx1, ax1);
        data_next.b1_dy = int_part(by1, ay1);
        data_next.b2_dx = int_part(bx2, ax1);
        data_next.b2_dy = int_part(by2, ay1);
        data_next.b_sx  = int_part(bx2, bx1);
        data_next.b_sy  = int_part(by2, by1);
        data_next.a1_dx = int_part(ax1, bx1);
        data_next.a1_dy = int_part(ay1, by1);
        data_next.a2_dx = int_part(ax2, bx1);
        data_next.a2_dy = int_part(ay2, by1);
        data_next.flags.decided = !box_ok || deg_a || deg_b;
        data_next.flags.early   = box_ok && (deg_a ? hit_a : hit_b);
        data_next.flags.coll    = coll;
    end

    // Stage advances when empty or when its beat is taken downstream.
    assign advance    = !valid_reg || out_ready;
    assign in_ready   = advance;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/sot_mult.sv
module sot_mult (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sot_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sot_pkg::prod_s_t out_data
);
    import sot_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    prod_s_t data_reg;
    prod_s_t data_next;
    logic    advance;

    // Eight cross product terms, one multiplier each.
    always_comb
    begin
        data_next.d1_p  = in_data.b1_dy * in_data.a_sx;
        data_next.d1_q  = in_data.b1_dx * in_data.a_sy;
        data_next.d2_p  = in_data.b2_dy * in_data.a_sx;
        data_next.d2_q  = in_data.b2_dx * in_data.a_sy;
        data_next.e1_p  = in_data.a1_dy * in_data.b_sx;
        data_next.e1_q  = in_data.a1_dx * in_data.b_sy;
        data_next.e2_p  = in_data.a2_dy * in_data.b_sx;
        data_next.e2_q  = in_data.a2_dx * in_data.b_sy;
        data_next.flags = in_data.flags;
    end

    assign advance    = !valid_reg || out_ready;
    assign in_ready   = advance;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/sot_decide.sv
module sot_decide (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sot_pkg::prod_s_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             overlap
);
    import sot_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    overlap_reg;
    logic    overlap_next;
    logic    advance;
    orient_t d1;
    orient_t d2;
    orient_t e1;
    orient_t e2;
    logic    cross_ok;

    // Orientation signs of each segment's ends against the other segment.
    assign d1 = orient_code(in_data.d1_p, in_data.d1_q);
    assign d2 = orient_code(in_data.d2_p, in_data.d2_q);
    assign e1 = orient_code(in_data.e1_p, in_data.e1_q);
    assign e2 = orient_code(in_data.e2_p, in_data.e2_q);

    // The first segment's ends straddle or touch the second segment's line.
    assign cross_ok = (e1 == OrientZero) || (e1 != e2);

    always_comb
    begin
        if (in_data.flags.decided)
        begin
            overlap_next = in_data.flags.early;
        end
        else if (d1 != OrientZero)
        begin
            overlap_next = (d1 == d2) ? 1'b0 : cross_ok;
        end
        else if (d2 == OrientZero)
        begin
            overlap_next = in_data.flags.coll;
        end
        else
        begin
            overlap_next = cross_ok;
        end
    end

    // Output register: holds the beat until it is taken.
    assign advance    = !valid_reg || out_ready;
    assign in_ready   = advance;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign out_valid = valid_reg;
    assign overlap   = overlap_reg;

endmodule

FILE: rtl/core/segment_overlap_test.sv
// Segment overlap test: decides whether two segments given in signed 16.16
// fixed point touch or cross, box edges and shared endpoints included. One
// segment pair is accepted every clock cycle unless back-pressure holds the
// input, and its answer passes through three register stages: coordinate
// differences and compares, eight 17x17 cross product multipliers, and the
// sign and decision logic feeding the output register. Back-pressure on the
// output stalls the pipeline stage by stage, so empty stages keep filling.
module segment_overlap_test (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sot_pkg::coord_t first_start_x,
    input  sot_pkg::coord_t first_start_y,
    input  sot_pkg::coord_t first_end_x,
    input  sot_pkg::coord_t first_end_y,
    input  sot_pkg::coord_t second_start_x,
    input  sot_pkg::coord_t second_start_y,
    input  sot_pkg::coord_t second_end_x,
    input  sot_pkg::coord_t second_end_y,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            overlap
);
    import sot_pkg::*;

    logic    front_valid;
    logic    front_ready;
    front_t  front_data;
    logic    mult_valid;
    logic    mult_ready;
    prod_s_t mult_data;

    // Stage one: differences, bounding box and special cases.
    sot_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ax1       (first_start_x),
        .ay1       (first_start_y),
        .ax2       (first_end_x),
        .ay2       (first_end_y),
        .bx1       (second_start_x),
        .by1       (second_start_y),
        .bx2       (second_end_x),
        .by2       (second_end_y),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // Stage two: cross product terms.
    sot_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .out_data  (mult_data)
    );

    // Stage three: orientation signs and final answer.
    sot_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .in_data   (mult_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .overlap   (overlap)
    );

endmodule
